// ===== hdl/lppc_pkg.sv =====
// Package for the lidar point projection and colorize block.
// Holds the widths, constants, register indexes and stage structs used by every hdl file.
// Depends on nothing.
package lppc_pkg;

    localparam int MAX_RANGE_MM = 20000;

    localparam int COORD_W  = 18;
    localparam int FOCAL_W  = 18;
    localparam int CENTER_W = 16;
    localparam int DIM_W    = 13;
    localparam int PIX_W    = 12;
    localparam int LEVEL_W  = 8;
    localparam int COLOR_W  = 8;

    localparam int DATA_W   = 32;
    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = $clog2(NUM_REGS * 4);
    localparam int IDX_W    = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_FOCAL_X  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FOCAL_Y  = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_CENTER_X = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_CENTER_Y = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_WIDTH    = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_HEIGHT   = IDX_W'(5);

    localparam int NUM_W  = 39;
    localparam int LIM_W  = 36;
    localparam int SQ_W   = 36;
    localparam int DVD_W  = 36;
    localparam int DVS_W  = 21;
    localparam int Q_W    = 13;
    localparam int SCALE_W = 16;
    localparam logic [SCALE_W-1:0] LEVEL_SCALE = SCALE_W'(65025);
    localparam int RADF_W = SQ_W + SCALE_W;

    localparam longint SAT_ROOT = 255 * MAX_RANGE_MM;
    localparam int     ROOT_W   = $clog2(SAT_ROOT);
    localparam int     RAD_W    = 2 * ROOT_W;
    localparam int     REM_W    = ROOT_W + 3;
    localparam longint SAT_RAD  = SAT_ROOT * SAT_ROOT;
    localparam int     LVL_SHIFT = ROOT_W + $clog2(MAX_RANGE_MM);
    localparam int     RECIP_W   = ROOT_W + 1;
    localparam longint LVL_RECIP =
        ((longint'(1) << LVL_SHIFT) + MAX_RANGE_MM - 1) / MAX_RANGE_MM;
    localparam int     QPROD_W   = ROOT_W + RECIP_W;
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    typedef struct packed {
        logic [FOCAL_W-1:0]  focal_x_q4;
        logic [FOCAL_W-1:0]  focal_y_q4;
        logic [CENTER_W-1:0] center_x_q4;
        logic [CENTER_W-1:0] center_y_q4;
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x_mm;
        logic signed [COORD_W-1:0] point_y_mm;
        logic signed [COORD_W-1:0] point_z_mm;
    } point_t;

    typedef struct packed {
        logic               visible;
        logic [PIX_W-1:0]   pixel_col;
        logic [PIX_W-1:0]   pixel_row;
        logic [LEVEL_W-1:0] depth_level;
        logic [COLOR_W-1:0] colour_blue;
        logic [COLOR_W-1:0] colour_green;
        logic [COLOR_W-1:0] colour_red;
    } result_t;

    typedef struct packed {
        logic              vis;
        logic [DVD_W-1:0]  dvd_x;
        logic [DVD_W-1:0]  dvd_y;
        logic [DVS_W-1:0]  dvs;
        logic [RADF_W-1:0] rad;
    } front_t;

    typedef struct packed {
        logic              vis;
        logic              sat;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [DVS_W-1:0]  dvs;
        logic [DVD_W-1:0]  rem_x;
        logic [DVD_W-1:0]  rem_y;
        logic [Q_W-1:0]    q_x;
        logic [Q_W-1:0]    q_y;
    } core_t;

    typedef struct packed {
        logic               vis;
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
        logic [LEVEL_W-1:0] lvl;
    } lvl_t;

endpackage

// ===== hdl/lppc_if.sv =====
// Valid/ready channel interfaces for points in and results out.
// Depends on lppc_pkg.
interface lppc_point_if import lppc_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x_mm;
    logic signed [COORD_W-1:0] point_y_mm;
    logic signed [COORD_W-1:0] point_z_mm;

    modport source (output valid, point_x_mm, point_y_mm, point_z_mm, input ready);
    modport sink (input valid, point_x_mm, point_y_mm, point_z_mm, output ready);
endinterface

interface lppc_result_if import lppc_pkg::*;;
    logic               valid;
    logic               ready;
    logic               visible;
    logic [PIX_W-1:0]   pixel_col;
    logic [PIX_W-1:0]   pixel_row;
    logic [LEVEL_W-1:0] depth_level;
    logic [COLOR_W-1:0] colour_blue;
    logic [COLOR_W-1:0] colour_green;
    logic [COLOR_W-1:0] colour_red;

    modport source (output valid, visible, pixel_col, pixel_row, depth_level,
                    colour_blue, colour_green, colour_red, input ready);
    modport sink (input valid, visible, pixel_col, pixel_row, depth_level,
                  colour_blue, colour_green, colour_red, output ready);
endinterface

// ===== hdl/lppc_cfg.sv =====
// APB register file holding the camera and image configuration.
// Depends on lppc_pkg.
module lppc_cfg
    import lppc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    logic [IDX_W-1:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x_q4   <= FOCAL_W'(8000);
            cfg_reg.focal_y_q4   <= FOCAL_W'(8000);
            cfg_reg.center_x_q4  <= CENTER_W'(5120);
            cfg_reg.center_y_q4  <= CENTER_W'(3840);
            cfg_reg.image_width  <= DIM_W'(640);
            cfg_reg.image_height <= DIM_W'(480);
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_FOCAL_X:  cfg_reg.focal_x_q4   <= pwdata[FOCAL_W-1:0];
                REG_FOCAL_Y:  cfg_reg.focal_y_q4   <= pwdata[FOCAL_W-1:0];
                REG_CENTER_X: cfg_reg.center_x_q4  <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y: cfg_reg.center_y_q4  <= pwdata[CENTER_W-1:0];
                REG_WIDTH:    cfg_reg.image_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   cfg_reg.image_height <= pwdata[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FOCAL_X:  prdata = DATA_W'(cfg_reg.focal_x_q4);
            REG_FOCAL_Y:  prdata = DATA_W'(cfg_reg.focal_y_q4);
            REG_CENTER_X: prdata = DATA_W'(cfg_reg.center_x_q4);
            REG_CENTER_Y: prdata = DATA_W'(cfg_reg.center_y_q4);
            REG_WIDTH:    prdata = DATA_W'(cfg_reg.image_width);
            REG_HEIGHT:   prdata = DATA_W'(cfg_reg.image_height);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== hdl/lppc_front.sv =====
// Front end: three stages of products, sums and visibility compares.
// Depends on lppc_pkg.
module lppc_front
    import lppc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_vld,
    input  point_t pt,
    input  cfg_t   cfg,
    output logic   out_vld,
    output front_t out
);

    logic [2:0] vld_reg;

    // stage 1
    logic signed [COORD_W:0]   ny, nz;
    logic signed [37:0]        p_fx_reg, p_fy_reg;
    logic signed [34:0]        p_cx_reg, p_cy_reg;
    logic signed [31:0]        p_lx_reg, p_ly_reg;
    logic [SQ_W-1:0]           sq_x_reg, sq_y_reg, sq_z_reg;
    logic signed [COORD_W-1:0] x1_reg;
    // stage 2
    logic signed [NUM_W-1:0]   num_x_reg, num_y_reg;
    logic signed [LIM_W-1:0]   lim_x_reg, lim_y_reg;
    logic [SQ_W-1:0]           sum_reg;
    logic signed [COORD_W-1:0] x2_reg;
    // stage 3
    front_t                    out_reg;
    logic signed [NUM_W-1:0]   x_ext;
    logic                      vis_x, vis_y;

    assign ny = -(COORD_W+1)'(pt.point_y_mm);
    assign nz = -(COORD_W+1)'(pt.point_z_mm);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_fx_reg <= $signed({1'b0, cfg.focal_x_q4}) * ny;
            p_fy_reg <= $signed({1'b0, cfg.focal_y_q4}) * nz;
            p_cx_reg <= $signed({1'b0, cfg.center_x_q4}) * pt.point_x_mm;
            p_cy_reg <= $signed({1'b0, cfg.center_y_q4}) * pt.point_x_mm;
            p_lx_reg <= $signed({1'b0, cfg.image_width}) * pt.point_x_mm;
            p_ly_reg <= $signed({1'b0, cfg.image_height}) * pt.point_x_mm;
            sq_x_reg <= SQ_W'(pt.point_x_mm * pt.point_x_mm);
            sq_y_reg <= SQ_W'(pt.point_y_mm * pt.point_y_mm);
            sq_z_reg <= SQ_W'(pt.point_z_mm * pt.point_z_mm);
            x1_reg   <= pt.point_x_mm;

            num_x_reg <= NUM_W'(p_fx_reg) + NUM_W'(p_cx_reg);
            num_y_reg <= NUM_W'(p_fy_reg) + NUM_W'(p_cy_reg);
            lim_x_reg <= LIM_W'(p_lx_reg) <<< 4;
            lim_y_reg <= LIM_W'(p_ly_reg) <<< 4;
            sum_reg   <= sq_x_reg + sq_y_reg + sq_z_reg;
            x2_reg    <= x1_reg;
        end
    end

    assign x_ext = NUM_W'(x2_reg);
    assign vis_x = (num_x_reg > 0) && (num_x_reg < NUM_W'(lim_x_reg));
    assign vis_y = (num_y_reg > 0) && (num_y_reg < NUM_W'(lim_y_reg));

    front_t nxt;
    always_comb
    begin
        nxt.vis   = (x2_reg > 0) && vis_x && vis_y;
        nxt.dvd_x = DVD_W'(num_x_reg + (x_ext <<< 3));
        nxt.dvd_y = DVD_W'(num_y_reg + (x_ext <<< 3));
        nxt.dvs   = {x2_reg[DVS_W-5:0], 4'b0000};
        nxt.rad   = RADF_W'(sum_reg * LEVEL_SCALE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= nxt;
    end

    assign out     = out_reg;
    assign out_vld = vld_reg[2];

endmodule

// ===== hdl/lppc_root_div.sv =====
// Digit-serial pipeline: range square root, one root bit per stage, alongside
// the two pixel dividers, one quotient bit per stage. Depends on lppc_pkg.
module lppc_root_div
    import lppc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_vld,
    input  front_t in,
    output logic   out_vld,
    output core_t  out
);

    core_t             stg_reg [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;
    core_t             init;

    always_comb
    begin
        init       = '0;
        init.vis   = in.vis;
        init.sat   = in.rad >= RADF_W'(SAT_RAD);
        init.rad   = in.rad[RAD_W-1:0];
        init.dvs   = in.dvs;
        init.rem_x = in.dvd_x;
        init.rem_y = in.dvd_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[ROOT_W-2:0], in_vld};
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        core_t            prev;
        core_t            nxt;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        logic [DVD_W-1:0] dtrial;

        if (j == 0)
        begin : g_first
            assign prev = init;
        end
        else
        begin : g_next
            assign prev = stg_reg[j-1];
        end

        always_comb
        begin
            nxt    = prev;
            cur    = {prev.rem[REM_W-3:0], prev.rad[RAD_W-1 -: 2]};
            trial  = REM_W'({prev.root, 2'b01});
            dtrial = '0;
            nxt.rad = prev.rad << 2;
            if (cur >= trial)
            begin
                nxt.rem  = cur - trial;
                nxt.root = {prev.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                nxt.rem  = cur;
                nxt.root = {prev.root[ROOT_W-2:0], 1'b0};
            end
            if (j < Q_W)
            begin
                dtrial = DVD_W'(prev.dvs) << (Q_W - 1 - j);
                if (prev.rem_x >= dtrial)
                begin
                    nxt.rem_x = prev.rem_x - dtrial;
                    nxt.q_x   = {prev.q_x[Q_W-2:0], 1'b1};
                end
                else
                    nxt.q_x = {prev.q_x[Q_W-2:0], 1'b0};
                if (prev.rem_y >= dtrial)
                begin
                    nxt.rem_y = prev.rem_y - dtrial;
                    nxt.q_y   = {prev.q_y[Q_W-2:0], 1'b1};
                end
                else
                    nxt.q_y = {prev.q_y[Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stg_reg[j] <= nxt;
        end
    end

    assign out     = stg_reg[ROOT_W-1];
    assign out_vld = vld_reg[ROOT_W-1];

endmodule

// ===== hdl/lppc_level.sv =====
// Level stages: range root times the reciprocal of the maximum range,
// then the jet colour and the output register. Depends on lppc_pkg.
module lppc_level
    import lppc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_vld,
    input  core_t   in,
    output logic    out_vld,
    output result_t out
);

    lvl_t                 lvl_reg;
    logic                 vld_reg;
    logic                 res_vld_reg;
    result_t              res_reg;
    lvl_t                 lvl_next;
    logic [QPROD_W-1:0]   quot;
    logic [LEVEL_W-1:0]   lvl;
    logic [LEVEL_W+1:0]   l4;
    result_t              res_next;

    assign quot = in.root * RECIP_W'(LVL_RECIP);

    always_comb
    begin
        lvl_next     = '0;
        lvl_next.vis = in.vis;
        lvl_next.col = (in.q_x > Q_W'(PIX_MAX)) ? PIX_MAX : in.q_x[PIX_W-1:0];
        lvl_next.row = (in.q_y > Q_W'(PIX_MAX)) ? PIX_MAX : in.q_y[PIX_W-1:0];
        lvl_next.lvl = in.sat ? '1 : quot[LVL_SHIFT +: LEVEL_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= in_vld;
            res_vld_reg <= vld_reg;
        end
    end

    assign lvl = lvl_reg.lvl;
    assign l4  = {lvl, 2'b00};

    always_comb
    begin
        res_next             = '0;
        res_next.visible     = 1'b1;
        res_next.pixel_col   = lvl_reg.col;
        res_next.pixel_row   = lvl_reg.row;
        res_next.depth_level = lvl;
        case (lvl[LEVEL_W-1 -: 2])
            2'b00:
            begin
                res_next.colour_blue  = '1;
                res_next.colour_green = l4[COLOR_W-1:0];
            end
            2'b01:
            begin
                res_next.colour_blue  = COLOR_W'((LEVEL_W+2)'(510) - l4);
                res_next.colour_green = '1;
            end
            2'b10:
            begin
                res_next.colour_green = '1;
                res_next.colour_red   = COLOR_W'(l4 - (LEVEL_W+2)'(510));
            end
            default:
            begin
                res_next.colour_green = COLOR_W'((LEVEL_W+2)'(1020) - l4);
                res_next.colour_red   = '1;
            end
        endcase
        if (!lvl_reg.vis)
            res_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lvl_reg <= lvl_next;
            res_reg <= res_next;
        end
    end

    assign out     = res_reg;
    assign out_vld = res_vld_reg;

endmodule

// ===== hdl/lidar_point_project_colorize_top.sv =====
// Top level of the lidar point projection and colorize block.
// Depends on lppc_pkg, lppc_if, lppc_cfg, lppc_front, lppc_root_div, lppc_level.
//
//  channel   kind           direction  transaction
//  points    valid/ready    in         one lidar point x, y, z in mm
//  results   valid/ready    out        visibility, pixel, depth level, jet colour
//  apb       APB slave      in         write/read of one configuration register
//
// Takes one point per cycle unless a result waits at the output; the square root
// yields one root bit per stage.
// Reset (rst_n low) clears every valid bit and loads the default registers.
// The whole pipeline holds while a result waits at the output; ready is low only then.
module lidar_point_project_colorize_top
    import lppc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lppc_point_if.sink        points,
    lppc_result_if.source     results,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg;
    point_t  pt;
    front_t  front;
    core_t   core;
    result_t res;
    logic    en;
    logic    front_vld;
    logic    core_vld;
    logic    res_vld;

    assign en            = !res_vld || results.ready;
    assign points.ready  = en;
    assign pt.point_x_mm = points.point_x_mm;
    assign pt.point_y_mm = points.point_y_mm;
    assign pt.point_z_mm = points.point_z_mm;

    lppc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lppc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (points.valid),
        .pt      (pt),
        .cfg     (cfg),
        .out_vld (front_vld),
        .out     (front)
    );

    lppc_root_div u_root_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (front_vld),
        .in      (front),
        .out_vld (core_vld),
        .out     (core)
    );

    lppc_level u_level (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (core_vld),
        .in      (core),
        .out_vld (res_vld),
        .out     (res)
    );

    assign results.valid        = res_vld;
    assign results.visible      = res.visible;
    assign results.pixel_col    = res.pixel_col;
    assign results.pixel_row    = res.pixel_row;
    assign results.depth_level  = res.depth_level;
    assign results.colour_blue  = res.colour_blue;
    assign results.colour_green = res.colour_green;
    assign results.colour_red   = res.colour_red;

endmodule

// ===== hdl/lppc_checker.sv =====
// Port-level assertions for the lidar point projection and colorize block.
// Depends on lppc_pkg; bound to lidar_point_project_colorize_top.
module lppc_checker
    import lppc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               visible,
    input logic [PIX_W-1:0]   pixel_col,
    input logic [PIX_W-1:0]   pixel_row,
    input logic [LEVEL_W-1:0] depth_level,
    input logic [COLOR_W-1:0] colour_blue,
    input logic [COLOR_W-1:0] colour_green,
    input logic [COLOR_W-1:0] colour_red
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_col)
            && $stable(depth_level) && $stable(visible))
        else $error("result changed while stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output slot");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> pixel_col == '0 && pixel_row == '0
            && depth_level == '0 && colour_blue == '0 && colour_green == '0
            && colour_red == '0)
        else $error("hidden point carries nonzero fields");

    a_jet_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible |-> colour_blue == '0 || colour_red == '0)
        else $error("jet colour mixes blue and red");

endmodule

bind lidar_point_project_colorize_top lppc_checker u_lppc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (points.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .visible      (results.visible),
    .pixel_col    (results.pixel_col),
    .pixel_row    (results.pixel_row),
    .depth_level  (results.depth_level),
    .colour_blue  (results.colour_blue),
    .colour_green (results.colour_green),
    .colour_red   (results.colour_red)
);

// ===== dv/lidar_point_project_colorize_top_test.sv =====
// Self-checking testbench for lidar_point_project_colorize_top: random and directed points,
// APB register phases, predicted projection, depth level and jet colour compared per result.
// Depends on lppc_pkg, lppc_if and the block's RTL.
`timescale 1ns / 1ps

module lidar_point_project_colorize_top_test;
    import lppc_pkg::*;

    localparam int RUN_LIMIT  = 400000;
    localparam int DRAIN_WAIT = 80;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lppc_point_if  pts ();
    lppc_result_if res ();

    lidar_point_project_colorize_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (pts),
        .results (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register mirror
    longint cam_fx, cam_fy, cam_cx, cam_cy, img_w, img_h;

    point_t  point_queue[$];
    result_t pixel_expect[$];
    int      send_idle_pct;
    int      stall_pct;
    logic    took;
    int      cycles;
    int      mismatches;
    int      results_seen;
    int      visible_seen;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint unsigned int_sqrt(longint unsigned t);
        longint unsigned acc;
        longint unsigned bt;
        acc = 0;
        bt  = 64'd1 << 62;
        while (bt > t)
            bt >>= 2;
        while (bt != 0)
        begin
            if (t >= acc + bt)
            begin
                t   = t - (acc + bt);
                acc = (acc >> 1) + bt;
            end
            else
                acc >>= 1;
            bt >>= 2;
        end
        return acc;
    endfunction

    function automatic bit axis_pixel(longint f, longint ctr, longint lim, longint c, longint x,
                                      output longint pix);
        longint num;
        num = f * (-c) + ctr * x;
        pix = 0;
        if (num <= 0 || num >= lim * 16 * x)
            return 1'b0;
        pix = (2 * num + 16 * x) / (32 * x);
        if (pix > 4095)
            pix = 4095;
        return 1'b1;
    endfunction

    function automatic result_t project_point(point_t p);
        result_t         r;
        longint          x, y, z, col, row;
        longint unsigned s, lvl;
        r = '0;
        x = p.point_x_mm;
        y = p.point_y_mm;
        z = p.point_z_mm;
        if (x <= 0)
            return r;
        if (!axis_pixel(cam_fx, cam_cx, img_w, y, x, col))
            return r;
        if (!axis_pixel(cam_fy, cam_cy, img_h, z, x, row))
            return r;
        s   = x * x + y * y + z * z;
        lvl = int_sqrt(s * 65025) / MAX_RANGE_MM;
        if (lvl > 255)
            lvl = 255;
        r.visible     = 1'b1;
        r.pixel_col   = col[11:0];
        r.pixel_row   = row[11:0];
        r.depth_level = lvl[7:0];
        if (lvl <= 63)
        begin
            r.colour_blue = 8'd255; r.colour_green = 8'(4 * lvl); r.colour_red = 8'd0;
        end
        else if (lvl <= 127)
        begin
            r.colour_blue = 8'(510 - 4 * lvl); r.colour_green = 8'd255; r.colour_red = 8'd0;
        end
        else if (lvl <= 191)
        begin
            r.colour_blue = 8'd0; r.colour_green = 8'd255; r.colour_red = 8'(4 * lvl - 510);
        end
        else
        begin
            r.colour_blue = 8'd0; r.colour_green = 8'(1020 - 4 * lvl); r.colour_red = 8'd255;
        end
        return r;
    endfunction

    function automatic point_t mk_point(longint x, longint y, longint z);
        point_t p;
        p.point_x_mm = COORD_W'(x);
        p.point_y_mm = COORD_W'(y);
        p.point_z_mm = COORD_W'(z);
        return p;
    endfunction

    function automatic longint clamp18(longint v);
        if (v > 131071)
            return 131071;
        if (v < -131072)
            return -131072;
        return v;
    endfunction

    // aim at a random pixel so most points land inside the image
    function automatic point_t aimed_point();
        longint x, u, v, y, z;
        x = $urandom_range(1, 3) == 1 ? longint'($urandom_range(1, 131071))
                                      : longint'($urandom_range(200, 30000));
        u = (img_w > 0) ? longint'($urandom_range(0, 32'(img_w * 16))) : 0;
        v = (img_h > 0) ? longint'($urandom_range(0, 32'(img_h * 16))) : 0;
        y = (cam_fx > 0) ? ((cam_cx - u) * x) / cam_fx : longint'($signed(18'($urandom)));
        z = (cam_fy > 0) ? ((cam_cy - v) * x) / cam_fy : longint'($signed(18'($urandom)));
        return mk_point(x, clamp18(y), clamp18(z));
    endfunction

    task automatic apb_write(logic [IDX_W-1:0] idx, longint value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FOCAL_X:  cam_fx = value & 18'h3FFFF;
            REG_FOCAL_Y:  cam_fy = value & 18'h3FFFF;
            REG_CENTER_X: cam_cx = value & 16'hFFFF;
            REG_CENTER_Y: cam_cy = value & 16'hFFFF;
            REG_WIDTH:    img_w  = value & 13'h1FFF;
            REG_HEIGHT:   img_h  = value & 13'h1FFF;
            default: ;
        endcase
    endtask

    task automatic set_camera(longint fx, longint fy, longint cx, longint cy, longint w,
                              longint h);
        apb_write(REG_FOCAL_X, fx);
        apb_write(REG_FOCAL_Y, fy);
        apb_write(REG_CENTER_X, cx);
        apb_write(REG_CENTER_Y, cy);
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 70)
                point_queue.push_back(aimed_point());
            else
                point_queue.push_back(mk_point($signed(18'($urandom)), $signed(18'($urandom)),
                                               $signed(18'($urandom))));
        end
    endtask

    task automatic drain();
        while (point_queue.size() != 0 || pts.valid || pixel_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic queue_directed();
        int lv[6];
        lv = '{63, 64, 127, 128, 191, 192};
        point_queue.push_back(mk_point(0, 0, 0));
        point_queue.push_back(mk_point(-131072, 0, 0));
        point_queue.push_back(mk_point(-1, 5, 5));
        point_queue.push_back(mk_point(131071, 0, 0));
        point_queue.push_back(mk_point(131071, 131071, 131071));
        point_queue.push_back(mk_point(131071, -131072, -131072));
        point_queue.push_back(mk_point(1, 0, 0));
        point_queue.push_back(mk_point(25, 16, 0));
        point_queue.push_back(mk_point(25, 15, 0));
        point_queue.push_back(mk_point(25, -24, 0));
        point_queue.push_back(mk_point(25, -23, 0));
        point_queue.push_back(mk_point(25, 0, 12));
        point_queue.push_back(mk_point(25, 0, -18));
        point_queue.push_back(mk_point(32, 2, 2));
        point_queue.push_back(mk_point(40000, 0, 0));
        foreach (lv[i])
            point_queue.push_back(mk_point((lv[i] * 20000 + 254) / 255, 0, 0));
        point_queue.push_back(mk_point(1000, 131071, -131072));
    endtask

    always @(posedge clk)
    begin
        took <= 1'b0;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (cycles > RUN_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILURE");
                $finish;
            end
            if (pts.valid && pts.ready)
            begin
                pixel_expect.push_back(project_point(mk_point(pts.point_x_mm, pts.point_y_mm,
                                                              pts.point_z_mm)));
                took <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t got, want;
        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.visible, res.pixel_col, res.pixel_row, res.depth_level,
                    res.colour_blue, res.colour_green, res.colour_red};
            results_seen <= results_seen + 1;
            if (got.visible)
                visible_seen <= visible_seen + 1;
            if (pixel_expect.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result %p", got);
                mismatches <= mismatches + 1;
            end
            else
            begin
                want = pixel_expect.pop_front();
                if (got != want)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    always @(negedge clk)
    begin : driver
        point_t nxt;
        if (rst_n)
        begin
            if (!pts.valid || took)
            begin
                if (point_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = point_queue.pop_front();
                    pts.valid      <= 1'b1;
                    pts.point_x_mm <= nxt.point_x_mm;
                    pts.point_y_mm <= nxt.point_y_mm;
                    pts.point_z_mm <= nxt.point_z_mm;
                end
                else
                    pts.valid <= 1'b0;
            end
            res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        pts.valid = 1'b0; pts.point_x_mm = '0; pts.point_y_mm = '0; pts.point_z_mm = '0;
        res.ready = 1'b0;
        took = 1'b0; cycles = 0; mismatches = 0; results_seen = 0; visible_seen = 0;
        send_idle_pct = 0; stall_pct = 0;
        cam_fx = 8000; cam_fy = 8000; cam_cx = 5120; cam_cy = 3840; img_w = 640; img_h = 480;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        queue_random(50);
        drain();

        send_idle_pct = 58;
        set_camera($urandom_range(1, 262143), $urandom_range(1, 262143),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(1, 4096), $urandom_range(1, 4096));
        queue_random(70);
        drain();

        send_idle_pct = 0;
        stall_pct = 58;
        set_camera(262143, 262143, 65535, 65535, 8191, 8191);
        queue_random(70);
        drain();

        send_idle_pct = 28;
        stall_pct = 28;
        set_camera(0, 0, 0, 0, 0, 0);
        queue_random(20);
        drain();
        set_camera(16, 16, 16, 16, 1, 1);
        queue_random(20);
        drain();

        set_camera(8000, 8000, 5120, 3840, 640, 480);
        queue_directed();
        queue_random(70);
        drain();

        send_idle_pct = 0;
        stall_pct = 0;
        set_camera($urandom_range(1000, 40000), $urandom_range(1000, 40000),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(1, 4096), 4096);
        queue_random(70);
        drain();

        $display("covered %0d results (%0d visible) over seven register settings", results_seen,
                 visible_seen);
        $display("idle and stall mixes from none to 58 percent on each side");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
